/* rtl/iptr_pkg.sv */
package iptr_pkg;

   // Table geometry and field widths.
   localparam int FRAMES     = 32;
   localparam int PID_BITS   = 8;
   localparam int PAGE_BITS  = 20;
   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int FRAME_OUT_W = 5;
   localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ACTIVE_W   = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port (byte address 4 * index).
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WINDOW = 2'd1;
   localparam logic [1:0] REG_ACTIVE = 2'd2;

   // Replacement modes.
   localparam logic MODE_LRU  = 1'b0;
   localparam logic MODE_WSET = 1'b1;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(32);

   // Configuration seen by the lookup engine.
   typedef struct packed {
      logic                  mode;
      logic [TIME_BITS-1:0]  window;
      logic [IDX_W-1:0]      last_idx;
   } cfg_type;

   // One entry of the frame memory.
   typedef struct packed {
      logic [PID_BITS-1:0]   owner;
      logic [PAGE_BITS-1:0]  page;
      logic [TIME_BITS-1:0]  stamp;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

/* rtl/inverted_page_table_replacer.sv */
// Channel  Direction  Handshake          Word
// req      in         req_valid/ready    process id, page number, write flag, time
// rsp      out        rsp_valid/ready    hit, frame index, fault flag, three totals
// csr      in/out     APB psel/penable   mode, window size, active frame count
//
// One access scans the active frame count, clamped to 1..32: the frame memory has one
// read port, so the scan reads one frame per cycle, then the finish step places the
// page and loads the result register.
// Reset is synchronous; it clears all frames to free, the totals and the control and configuration registers.
// A new request is taken while a result still waits; the engine holds in its
// last step only if the result register is still full.
module inverted_page_table_replacer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [iptr_pkg::PID_BITS-1:0]     req_process_id,
   input  logic [iptr_pkg::PAGE_BITS-1:0]    req_page_number,
   input  logic                              req_is_write,
   input  logic [iptr_pkg::TIME_BITS-1:0]    req_access_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [iptr_pkg::FRAME_OUT_W-1:0]  rsp_frame_index,
   output logic                              rsp_page_fault,
   output logic [iptr_pkg::COUNT_BITS-1:0]   rsp_reads_seen,
   output logic [iptr_pkg::COUNT_BITS-1:0]   rsp_writes_seen,
   output logic [iptr_pkg::COUNT_BITS-1:0]   rsp_faults_seen,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [iptr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iptr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iptr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import iptr_pkg::*;

   cfg_type cfg;

   iptr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Control state.
   state_type              state_ff, state_in;
   logic [FRAMES-1:0]      valid_ff, valid_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   issue_ff, issue_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [COUNT_BITS-1:0]  reads_ff, reads_in;
   logic [COUNT_BITS-1:0]  writes_ff, writes_in;
   logic [COUNT_BITS-1:0]  faults_ff, faults_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Request word and scan results.
   logic [PID_BITS-1:0]    pid_ff, pid_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       found_at_ff, found_at_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_at_ff, free_at_in;
   logic                   best_ff, best_in;
   logic [IDX_W-1:0]       best_at_ff, best_at_in;
   logic [TIME_BITS-1:0]   best_stamp_ff, best_stamp_in;
   logic                   swept_ff, swept_in;
   logic [IDX_W-1:0]       sweep_at_ff, sweep_at_in;
   logic [FRAMES-1:0]      sweep_mask_ff, sweep_mask_in;

   // Result register.
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [COUNT_BITS-1:0]  rsp_reads_ff, rsp_reads_in;
   logic [COUNT_BITS-1:0]  rsp_writes_ff, rsp_writes_in;
   logic [COUNT_BITS-1:0]  rsp_faults_ff, rsp_faults_in;

   // Frame memory.
   entry_type              frame_mem [FRAMES];
   entry_type              mem_rdata_ff;
   entry_type              mem_wdata;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;

   logic                   entry_valid;
   logic                   entry_match;
   logic [TIME_BITS-1:0]   entry_age;
   logic                   accept;
   logic                   out_free;
   logic [IDX_W-1:0]       where;

   assign accept      = req_valid & req_ready;
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign entry_valid = valid_ff[chk_idx_ff];
   assign entry_match = (mem_rdata_ff.owner == pid_ff) && (mem_rdata_ff.page == page_ff);
   assign entry_age   = time_ff - mem_rdata_ff.stamp;
   assign mem_wdata   = '{owner: pid_ff, page: page_ff, stamp: time_ff};

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (issue_ff) begin
         mem_rdata_ff <= frame_mem[rd_idx_ff];
      end
   end

   // Frame choice: the matching frame on a hit, else the victim on a miss.
   always_comb begin
      if (found_ff) begin
         where = found_at_ff;
      end else if (free_ff) begin
         where = free_at_ff;
      end else if (cfg.mode == MODE_WSET && swept_ff) begin
         where = sweep_at_ff;
      end else begin
         where = best_at_ff;
      end
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      rd_idx_in     = rd_idx_ff;
      issue_in      = 1'b0;
      chk_vld_in    = 1'b0;
      chk_idx_in    = rd_idx_ff;
      reads_in      = reads_ff;
      writes_in     = writes_ff;
      faults_in     = faults_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      pid_in        = pid_ff;
      page_in       = page_ff;
      time_in       = time_ff;
      found_in      = found_ff;
      found_at_in   = found_at_ff;
      free_in       = free_ff;
      free_at_in    = free_at_ff;
      best_in       = best_ff;
      best_at_in    = best_at_ff;
      best_stamp_in = best_stamp_ff;
      swept_in      = swept_ff;
      sweep_at_in   = sweep_at_ff;
      sweep_mask_in = sweep_mask_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_reads_in  = rsp_reads_ff;
      rsp_writes_in = rsp_writes_ff;
      rsp_faults_in = rsp_faults_ff;
      mem_we        = 1'b0;
      mem_waddr     = chk_idx_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               pid_in        = req_process_id;
               page_in       = req_page_number;
               time_in       = req_access_time;
               found_in      = 1'b0;
               free_in       = 1'b0;
               best_in       = 1'b0;
               swept_in      = 1'b0;
               sweep_mask_in = '0;
               rd_idx_in     = '0;
               issue_in      = 1'b1;
               if (req_is_write) begin
                  writes_in = writes_ff + COUNT_BITS'(1);
               end else begin
                  reads_in = reads_ff + COUNT_BITS'(1);
               end
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle up to the last active frame.
            if (issue_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff;
               if (rd_idx_ff != cfg.last_idx) begin
                  issue_in  = 1'b1;
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            // Check the frame read in the previous cycle.
            if (chk_vld_ff) begin
               if (!entry_valid) begin
                  free_in    = 1'b1;
                  free_at_in = chk_idx_ff;
               end else begin
                  if (entry_match) begin
                     found_in    = 1'b1;
                     found_at_in = chk_idx_ff;
                     mem_we      = 1'b1;
                  end
                  if (!best_ff || mem_rdata_ff.stamp < best_stamp_ff) begin
                     best_in       = 1'b1;
                     best_at_in    = chk_idx_ff;
                     best_stamp_in = mem_rdata_ff.stamp;
                  end
                  if (mem_rdata_ff.owner == pid_ff && entry_age > cfg.window) begin
                     swept_in                  = 1'b1;
                     sweep_at_in               = chk_idx_ff;
                     sweep_mask_in[chk_idx_ff] = 1'b1;
                  end
               end
               if (chk_idx_ff == cfg.last_idx) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // Place the page on a miss and load the result word.
            if (out_free) begin
               if (!found_ff) begin
                  faults_in = faults_ff + COUNT_BITS'(1);
                  if (!free_ff && cfg.mode == MODE_WSET && swept_ff) begin
                     valid_in = valid_ff & ~sweep_mask_ff;
                  end
                  valid_in[where] = 1'b1;
                  mem_we          = 1'b1;
                  mem_waddr       = where;
               end
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = found_ff;
               rsp_frame_in  = FRAME_OUT_W'(where);
               rsp_reads_in  = reads_ff;
               rsp_writes_in = writes_ff;
               rsp_faults_in = found_ff ? faults_ff : faults_ff + COUNT_BITS'(1);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         issue_ff     <= 1'b0;
         chk_vld_ff   <= 1'b0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      pid_ff        <= pid_in;
      page_ff       <= page_in;
      time_ff       <= time_in;
      found_ff      <= found_in;
      found_at_ff   <= found_at_in;
      free_ff       <= free_in;
      free_at_ff    <= free_at_in;
      best_ff       <= best_in;
      best_at_ff    <= best_at_in;
      best_stamp_ff <= best_stamp_in;
      swept_ff      <= swept_in;
      sweep_at_ff   <= sweep_at_in;
      sweep_mask_ff <= sweep_mask_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_reads_ff  <= rsp_reads_in;
      rsp_writes_ff <= rsp_writes_in;
      rsp_faults_ff <= rsp_faults_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_page_fault  = ~rsp_hit_ff;
   assign rsp_frame_index = rsp_frame_ff;
   assign rsp_reads_seen  = rsp_reads_ff;
   assign rsp_writes_seen = rsp_writes_ff;
   assign rsp_faults_seen = rsp_faults_ff;

endmodule

/* rtl/iptr_csr.sv */
module iptr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [iptr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [iptr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iptr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output iptr_pkg::cfg_type                 cfg
);
   import iptr_pkg::*;

   logic                  mode_ff, mode_in;
   logic [TIME_BITS-1:0]  window_ff, window_in;
   logic [ACTIVE_W-1:0]   active_ff, active_in;
   logic                  wr_en;
   logic [1:0]            reg_sel;
   logic [31:0]           active_wide;
   logic [IDX_W:0]        used;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Register writes; an address beyond the list is ignored.
   always_comb begin
      mode_in   = mode_ff;
      window_in = window_ff;
      active_in = active_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MODE:   mode_in   = csr_pwdata[0];
            REG_WINDOW: window_in = csr_pwdata[TIME_BITS-1:0];
            REG_ACTIVE: active_in = csr_pwdata[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LRU;
         window_ff <= '0;
         active_ff <= ACTIVE_RESET;
      end else begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
         active_ff <= active_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_sel)
         REG_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         REG_WINDOW: csr_prdata = CSR_DATA_W'(window_ff);
         REG_ACTIVE: csr_prdata = CSR_DATA_W'(active_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Clamp the active frame count to 1..FRAMES and hand out the last index.
   assign active_wide = 32'(active_ff);
   always_comb begin
      if (active_wide == 32'd0) begin
         used = (IDX_W+1)'(1);
      end else if (active_wide > 32'(FRAMES)) begin
         used = (IDX_W+1)'(FRAMES);
      end else begin
         used = (IDX_W+1)'(active_ff);
      end
   end

   assign cfg.mode     = mode_ff;
   assign cfg.window   = window_ff;
   assign cfg.last_idx = IDX_W'(used - (IDX_W+1)'(1));

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import iptr_pkg::*;

   // One access word and the result word it causes.
   typedef struct {
      logic [PID_BITS-1:0]  pid;
      logic [PAGE_BITS-1:0] page;
      logic                 is_write;
      logic [TIME_BITS-1:0] access_time;
   } access_word_type;

   typedef struct {
      logic                   hit;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   fault;
      logic [COUNT_BITS-1:0]  reads;
      logic [COUNT_BITS-1:0]  writes;
      logic [COUNT_BITS-1:0]  faults;
   } lookup_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PID_BITS-1:0]    req_process_id = '0;
   logic [PAGE_BITS-1:0]   req_page_number = '0;
   logic                   req_is_write = 1'b0;
   logic [TIME_BITS-1:0]   req_access_time = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_hit;
   logic [FRAME_OUT_W-1:0] rsp_frame_index;
   logic                   rsp_page_fault;
   logic [COUNT_BITS-1:0]  rsp_reads_seen;
   logic [COUNT_BITS-1:0]  rsp_writes_seen;
   logic [COUNT_BITS-1:0]  rsp_faults_seen;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   inverted_page_table_replacer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_process_id  (req_process_id),
      .req_page_number (req_page_number),
      .req_is_write    (req_is_write),
      .req_access_time (req_access_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_frame_index (rsp_frame_index),
      .rsp_page_fault  (rsp_page_fault),
      .rsp_reads_seen  (rsp_reads_seen),
      .rsp_writes_seen (rsp_writes_seen),
      .rsp_faults_seen (rsp_faults_seen),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the frame table, totals and registers.
   logic                  tbl_valid [FRAMES];
   logic [PID_BITS-1:0]   tbl_owner [FRAMES];
   logic [PAGE_BITS-1:0]  tbl_page  [FRAMES];
   logic [TIME_BITS-1:0]  tbl_stamp [FRAMES];
   logic [COUNT_BITS-1:0] read_count;
   logic [COUNT_BITS-1:0] write_count;
   logic [COUNT_BITS-1:0] fault_count;
   logic                  shadow_mode;
   logic [TIME_BITS-1:0]  shadow_window;
   logic [ACTIVE_W-1:0]   shadow_active;

   access_word_type   pending_accesses [$];
   lookup_result_type awaited_results [$];
   int                queued_count = 0;
   int                results_seen = 0;
   int                err_count = 0;
   bit                calm = 1'b0;

   // Oldest stamp among the first n frames; a tie keeps the lower index.
   function automatic int oldest_frame(int n);
      int best;
      best = 0;
      for (int i = 1; i < n; i++)
         if (tbl_stamp[i] < tbl_stamp[best]) best = i;
      return best;
   endfunction

   // Looks one access up in the shadow table and applies its effects.
   function automatic lookup_result_type predict_access(access_word_type w);
      lookup_result_type r;
      int n, found_at, free_at, where;
      bit found, have_free, freed;
      logic [TIME_BITS-1:0] age;
      n = shadow_active;
      if (n == 0) n = 1;
      if (n > FRAMES) n = FRAMES;
      found = 1'b0;
      have_free = 1'b0;
      found_at = 0;
      free_at = 0;
      where = 0;
      if (w.is_write) write_count++;
      else read_count++;
      for (int i = 0; i < n; i++) begin
         if (!tbl_valid[i]) begin
            have_free = 1'b1;
            free_at = i;
         end else if (tbl_page[i] == w.page && tbl_owner[i] == w.pid) begin
            found = 1'b1;
            found_at = i;
            tbl_stamp[i] = w.access_time;
         end
      end
      if (found) begin
         where = found_at;
      end else begin
         fault_count++;
         if (have_free) begin
            where = free_at;
         end else if (shadow_mode == MODE_LRU) begin
            where = oldest_frame(n);
         end else begin
            // Sweep this process's stale frames, then reuse the last one freed.
            freed = 1'b0;
            for (int i = 0; i < n; i++) begin
               age = w.access_time - tbl_stamp[i];
               if (tbl_valid[i] && tbl_owner[i] == w.pid && age > shadow_window) begin
                  tbl_valid[i] = 1'b0;
                  tbl_owner[i] = '0;
                  tbl_page[i] = '0;
                  tbl_stamp[i] = '0;
                  freed = 1'b1;
                  where = i;
               end
            end
            if (!freed) where = oldest_frame(n);
         end
         tbl_valid[where] = 1'b1;
         tbl_owner[where] = w.pid;
         tbl_page[where] = w.page;
         tbl_stamp[where] = w.access_time;
      end
      r.hit = found;
      r.frame = FRAME_OUT_W'(where);
      r.fault = !found;
      r.reads = read_count;
      r.writes = write_count;
      r.faults = fault_count;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endtask

   // Driver: presents queued words, with random idle bursts between them.
   access_word_type on_bus;
   int              send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) awaited_results.push_back(predict_access(on_bus));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               on_bus = pending_accesses.pop_front();
               req_valid <= 1'b1;
               req_process_id <= on_bus.pid;
               req_page_number <= on_bus.page;
               req_is_write <= on_bus.is_write;
               req_access_time <= on_bus.access_time;
               if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs up the input.
   int stall_left = 0;
   int hold_left = 0;
   bit held_once = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!held_once && results_seen >= 300) begin
         held_once = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 13);
      end
   end

   // Monitor: every result word is checked against the oldest prediction.
   always @(posedge clock) begin
      lookup_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            note_failure($sformatf(
               "unexpected result: hit=%0d frame=%0d fault=%0d reads=%0d writes=%0d faults=%0d",
               rsp_hit, rsp_frame_index, rsp_page_fault, rsp_reads_seen, rsp_writes_seen,
               rsp_faults_seen));
         end else begin
            e = awaited_results.pop_front();
            if (rsp_hit !== e.hit || rsp_frame_index !== e.frame ||
                rsp_page_fault !== e.fault || rsp_reads_seen !== e.reads ||
                rsp_writes_seen !== e.writes || rsp_faults_seen !== e.faults) begin
               note_failure({
                  $sformatf("mismatch: expected hit=%0d frame=%0d fault=%0d r=%0d w=%0d f=%0d",
                            e.hit, e.frame, e.fault, e.reads, e.writes, e.faults),
                  $sformatf(", got hit=%0d frame=%0d fault=%0d r=%0d w=%0d f=%0d",
                            rsp_hit, rsp_frame_index, rsp_page_fault, rsp_reads_seen,
                            rsp_writes_seen, rsp_faults_seen)});
            end
         end
      end
   end

   task automatic queue_access(input logic [PID_BITS-1:0] pid, input logic [PAGE_BITS-1:0] page,
                               input logic is_write, input logic [TIME_BITS-1:0] t);
      access_word_type w;
      w.pid = pid;
      w.page = page;
      w.is_write = is_write;
      w.access_time = t;
      pending_accesses.push_back(w);
      queued_count++;
   endtask

   // Waits until every queued word has produced its result.
   task automatic settle();
      while (results_seen < queued_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the shadow follows at the write edge.
   task automatic csr_write(input logic [1:0] reg_idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({reg_idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (reg_idx)
         REG_MODE:   shadow_mode = value[0];
         REG_WINDOW: shadow_window = value;
         REG_ACTIVE: shadow_active = value[ACTIVE_W-1:0];
         default: ;
      endcase
   endtask

   // Sequencer: directed accesses, then randomized phases under varied settings.
   initial begin
      int active_choices [13];
      logic [PID_BITS-1:0]  pid_pool [3];
      logic [PAGE_BITS-1:0] page_pool [32];
      logic [TIME_BITS-1:0] clock_now;
      logic [CSR_DATA_W-1:0] window_pick;
      int n_eff, page_span;

      active_choices = '{1, 2, 3, 4, 5, 8, 32, 0, 6, 63, 16, 40, 3};
      for (int i = 0; i < FRAMES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_owner[i] = '0;
         tbl_page[i] = '0;
         tbl_stamp[i] = '0;
      end
      read_count = '0;
      write_count = '0;
      fault_count = '0;
      shadow_mode = MODE_LRU;
      shadow_window = '0;
      shadow_active = ACTIVE_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Extremes and the first fills from the top frame down.
      csr_write(REG_MODE, CSR_DATA_W'(MODE_LRU));
      csr_write(REG_WINDOW, 32'd0);
      csr_write(REG_ACTIVE, 32'd32);
      queue_access(8'd0, 20'h00000, 1'b0, 32'd0);
      queue_access(8'd0, 20'h00000, 1'b1, 32'd5);
      queue_access(8'hFF, 20'hFFFFF, 1'b1, 32'd10);
      settle();

      // The same page placed again below a resident copy, then two matching frames.
      csr_write(REG_ACTIVE, 32'd2);
      queue_access(8'd0, 20'h00000, 1'b1, 32'd20);
      settle();
      csr_write(REG_ACTIVE, 32'd32);
      queue_access(8'd0, 20'h00000, 1'b0, 32'd30);
      settle();

      // Full table in LRU mode, including a tie on the oldest stamp.
      csr_write(REG_ACTIVE, 32'd2);
      queue_access(8'd1, 20'h00005, 1'b0, 32'd31);
      queue_access(8'd2, 20'h00007, 1'b0, 32'd32);
      queue_access(8'd3, 20'h00009, 1'b0, 32'd32);
      queue_access(8'd4, 20'h00001, 1'b0, 32'd32);
      settle();

      // Working set: one stale frame freed, then a process with none falls back to LRU.
      csr_write(REG_MODE, CSR_DATA_W'(MODE_WSET));
      queue_access(8'd2, 20'h00008, 1'b0, 32'd40);
      queue_access(8'd9, 20'h00009, 1'b0, 32'd41);
      settle();
      csr_write(REG_ACTIVE, 32'd4);
      queue_access(8'd9, 20'h0000A, 1'b0, 32'd50);
      queue_access(8'd9, 20'h0000B, 1'b1, 32'd51);
      settle();

      // Several stale frames freed at once; the freed ones are reused afterwards.
      csr_write(REG_WINDOW, 32'd5);
      queue_access(8'd9, 20'h0000C, 1'b0, 32'd60);
      queue_access(8'd9, 20'h0000D, 1'b0, 32'd61);
      queue_access(8'd9, 20'h0000C, 1'b1, 32'd62);
      queue_access(8'hFF, 20'hFFFFF, 1'b1, 32'hFFFF_FFFF);
      queue_access(8'hFF, 20'hFFFFF, 1'b0, 32'd3);
      settle();

      // Random phases: small pools of processes and pages so hits and evictions mix.
      clock_now = 32'd100;
      for (int phase = 0; phase < 13; phase++) begin
         n_eff = active_choices[phase];
         if (n_eff == 0) n_eff = 1;
         if (n_eff > FRAMES) n_eff = FRAMES;
         page_span = n_eff / 2 + 1;
         case ($urandom_range(0, 3))
            0: window_pick = 32'd0;
            1: window_pick = 32'($urandom_range(1, 40));
            2: window_pick = 32'hFFFF_FFFF;
            default: window_pick = $urandom;
         endcase
         if (phase == 2) window_pick = 32'hFFFF_FFFF;
         if (phase == 3) window_pick = 32'd0;
         csr_write(REG_MODE, (phase < 2) ? CSR_DATA_W'(phase)
                                         : CSR_DATA_W'($urandom_range(0, 1)));
         csr_write(REG_WINDOW, window_pick);
         csr_write(REG_ACTIVE, CSR_DATA_W'(active_choices[phase]));
         for (int i = 0; i < 3; i++) pid_pool[i] = PID_BITS'($urandom);
         for (int i = 0; i < 32; i++) page_pool[i] = PAGE_BITS'($urandom);
         if ($urandom_range(0, 2) == 0) clock_now = $urandom;
         if (phase == 6) clock_now = 32'hFFFF_FF80;
         if (phase == 12) calm = 1'b1;
         for (int k = 0; k < 75; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               queue_access(PID_BITS'($urandom), PAGE_BITS'($urandom),
                            1'($urandom_range(0, 1)), $urandom);
            end else begin
               if ($urandom_range(0, 9) == 0) clock_now += 32'($urandom_range(0, 200));
               else clock_now += 32'($urandom_range(0, 6));
               queue_access(pid_pool[$urandom_range(0, 2)],
                            page_pool[$urandom_range(0, page_span - 1)],
                            1'($urandom_range(0, 1)), clock_now);
            end
         end
         settle();
      end

      repeat (40) @(posedge clock);
      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d predicted results never arrived",
                                awaited_results.size()));
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/iptr_pkg.sv
rtl/iptr_csr.sv
rtl/inverted_page_table_replacer.sv
tb/tb.sv
